@@ rtl/jrcm_pkg.sv @@
// shared types and constants for the joystick range calibrate and map block
// no dependencies
package jrcm_pkg;

	// opcode of an input item
	typedef enum logic [1:0] {
		OP_CENTRE = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_FINISH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_TRAVEL_MIN = 2'd0,
		REG_OUT_LOW    = 2'd1,
		REG_OUT_HIGH   = 2'd2
	} reg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DIV,
		ST_STORE,
		ST_OUT
	} state_t;

	// map numbers in evaluation order
	typedef enum logic [1:0] {
		MAP_AX = 2'd0,
		MAP_AY = 2'd1,
		MAP_SX = 2'd2,
		MAP_SY = 2'd3
	} map_t;

	localparam int OUT_W      = 16;
	localparam int TRAVEL_W   = 10;
	localparam int CFG_W      = 16;
	localparam int PROD_W     = 2 * OUT_W;
	localparam int MUL_STEPS  = OUT_W;
	localparam int DIV_STEPS  = PROD_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [TRAVEL_W-1:0] TRAVEL_MIN_RST = 10'd256;
	localparam logic [OUT_W-1:0]    OUT_LOW_RST    = 16'd0;
	localparam logic [OUT_W-1:0]    OUT_HIGH_RST   = 16'd1023;

endpackage

@@ rtl/jrcm_in_if.sv @@
// input channel of the calibrate and map block: valid/ready plus one sample item
// imports jrcm_pkg, though the opcode is declared as a plain two-bit field
interface jrcm_in_if
	import jrcm_pkg::*;
#(
	parameter int ADC_BITS = 10
);
	logic                valid;
	logic                ready;
	logic [1:0]          opcode;
	logic [ADC_BITS-1:0] x_sample;
	logic [ADC_BITS-1:0] y_sample;

	modport source (output valid, opcode, x_sample, y_sample, input ready);
	modport sink (input valid, opcode, x_sample, y_sample, output ready);
endinterface

@@ rtl/jrcm_out_if.sv @@
// output channel of the calibrate and map block: valid/ready plus one result item
// depends on jrcm_pkg for the field width
interface jrcm_out_if
	import jrcm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] aligned_x;
	logic [OUT_W-1:0] aligned_y;
	logic [OUT_W-1:0] scaled_x;
	logic [OUT_W-1:0] scaled_y;
	logic             is_calibrated;
	logic             finish_ok;

	modport source (output valid, aligned_x, aligned_y, scaled_x, scaled_y, is_calibrated,
		finish_ok, input ready);
	modport sink (input valid, aligned_x, aligned_y, scaled_x, scaled_y, is_calibrated,
		finish_ok, output ready);
endinterface

@@ rtl/joystick_range_calibrate_and_map_top.sv @@
// joystick min/max calibration with linear mapping onto an aligned and an output range
// depends on jrcm_pkg, jrcm_in_if and jrcm_out_if
//
// Each input item carries an opcode and one X/Y sample pair and yields exactly one result
// item. Opcode 0 captures the centre and restarts tracking, opcode 1 widens the min/max
// limits, opcode 2 checks the travel against travel_min and, if both axes pass, freezes the
// aligned range and sets calibration, opcode 3 only reads. The tracking state is updated in
// the accept cycle. While uncalibrated the result carries the raw samples and passes from
// ST_OUT straight into the output register. Once calibrated, four linear maps (aligned x,
// aligned y, then scaled x, scaled y from the aligned values) run one after another on a
// single shared unit: a setup step (ST_LOAD), a one-bit-per-cycle shift-and-add multiplier,
// a one-bit-per-cycle restoring divider and a writeback step (ST_STORE); after the last map
// the result passes through ST_OUT into the output register. The block takes one item at a
// time; the output register lets the next item in while a result still waits downstream.
// Configuration is written through cfg_we/cfg_idx/cfg_data; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module joystick_range_calibrate_and_map_top
	import jrcm_pkg::*;
#(
	parameter int ADC_BITS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	jrcm_in_if.sink          in_ch,
	jrcm_out_if.source       out_ch,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int DIFF_W = OUT_W + 1;
	localparam int TW     = (ADC_BITS > TRAVEL_W) ? ADC_BITS : TRAVEL_W;

	// configuration registers
	logic [TRAVEL_W-1:0] travel_min_q;
	logic [OUT_W-1:0]    out_low_q;
	logic [OUT_W-1:0]    out_high_q;

	// calibration state
	logic [ADC_BITS-1:0] centre_x_q, centre_y_q;
	logic [ADC_BITS-1:0] low_x_q, high_x_q, low_y_q, high_y_q;
	logic [ADC_BITS-1:0] aligned_low_q, aligned_high_q;
	logic                centred_q, calibrated_q;

	// item under work
	logic [ADC_BITS-1:0] x_q, y_q;
	logic                ok_q;

	// sequencer
	state_t           state_q, state_d;
	logic [1:0]       map_idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             load_out;
	logic             last_map;

	// shared map unit
	logic [PROD_W-1:0]   prod_q;
	logic [OUT_W-1:0]    mag_b_q;
	logic                neg_q;
	logic [ADC_BITS-1:0] span_q;
	logic [ADC_BITS-1:0] rem_q;
	logic [OUT_W-1:0]    olo_q;
	logic [OUT_W-1:0]    ax_q, ay_q, sx_q, sy_q;

	// output register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_ax_q, out_ay_q, out_sx_q, out_sy_q;
	logic             out_cal_q, out_ok_q;

	// next tracking state for the item being accepted
	logic [ADC_BITS-1:0] low_x_d, high_x_d, low_y_d, high_y_d;
	logic [ADC_BITS-1:0] centre_x_d, centre_y_d;
	logic [ADC_BITS-1:0] aligned_low_d, aligned_high_d;
	logic                centred_d, calibrated_d, ok_d;
	logic [TW-1:0]       travel_x, travel_y;
	op_t                 op;

	// map setup operands
	logic [OUT_W-1:0]    v_sel, olo_sel, ohi_sel;
	logic [ADC_BITS-1:0] ilo_sel, ihi_sel;
	logic [DIFF_W-1:0]   diff_a, diff_b;

	// datapath step values
	logic [OUT_W:0]      mul_sum;
	logic [ADC_BITS:0]   div_trial, div_sub;
	logic                div_take;
	logic [OUT_W-1:0]    quo, map_res;

	assign op = op_t'(in_ch.opcode);

	// ---------------------------------------------------------------------------------
	// tracking update, evaluated on the sample being accepted
	// ---------------------------------------------------------------------------------
	always_comb begin
		centre_x_d     = centre_x_q;
		centre_y_d     = centre_y_q;
		low_x_d        = low_x_q;
		high_x_d       = high_x_q;
		low_y_d        = low_y_q;
		high_y_d       = high_y_q;
		aligned_low_d  = aligned_low_q;
		aligned_high_d = aligned_high_q;
		centred_d      = centred_q;
		calibrated_d   = calibrated_q;
		ok_d           = 1'b0;
		travel_x       = TW'(high_x_q - low_x_q);
		travel_y       = TW'(high_y_q - low_y_q);
		case (op)
			OP_CENTRE: begin
				centre_x_d   = in_ch.x_sample;
				centre_y_d   = in_ch.y_sample;
				low_x_d      = in_ch.x_sample;
				high_x_d     = in_ch.x_sample;
				low_y_d      = in_ch.y_sample;
				high_y_d     = in_ch.y_sample;
				centred_d    = 1'b1;
				calibrated_d = 1'b0;
			end
			OP_SAMPLE: begin
				if (centred_q) begin
					// a limit only moves on the far side of the centre
					if (in_ch.x_sample < centre_x_q && in_ch.x_sample < low_x_q)
						low_x_d = in_ch.x_sample;
					if (in_ch.x_sample > centre_x_q && in_ch.x_sample > high_x_q)
						high_x_d = in_ch.x_sample;
					if (in_ch.y_sample < centre_y_q && in_ch.y_sample < low_y_q)
						low_y_d = in_ch.y_sample;
					if (in_ch.y_sample > centre_y_q && in_ch.y_sample > high_y_q)
						high_y_d = in_ch.y_sample;
				end
			end
			OP_FINISH: begin
				if (centred_q && travel_x >= TW'(travel_min_q)
						&& travel_y >= TW'(travel_min_q)) begin
					calibrated_d   = 1'b1;
					aligned_low_d  = (low_x_q < low_y_q) ? low_x_q : low_y_q;
					aligned_high_d = (high_x_q > high_y_q) ? high_x_q : high_y_q;
					ok_d           = 1'b1;
				end
			end
			default: begin
				// read leaves the state as it is
			end
		endcase
	end

	// ---------------------------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign last_map = (map_idx_q == MAP_SY);

	always_comb begin
		state_d     = state_q;
		accept      = 1'b0;
		load_out    = 1'b0;
		in_ch.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					accept  = 1'b1;
					// raw pass-through needs no map
					state_d = calibrated_d ? ST_LOAD : ST_OUT;
				end
			end
			ST_LOAD: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == CNT_W'(MUL_STEPS - 1))
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = ST_STORE;
			end
			ST_STORE: begin
				state_d = last_map ? ST_OUT : ST_LOAD;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_idx_q <= '0;
			cnt_q     <= '0;
		end else begin
			if (accept)
				map_idx_q <= MAP_AX;
			else if (state_q == ST_STORE)
				map_idx_q <= map_idx_q + 2'd1;
			if (state_q == ST_MUL || state_q == ST_DIV) begin
				if (state_d != state_q)
					cnt_q <= '0;
				else
					cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// configuration and calibration state
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_min_q <= TRAVEL_MIN_RST;
			out_low_q    <= OUT_LOW_RST;
			out_high_q   <= OUT_HIGH_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_TRAVEL_MIN: travel_min_q <= cfg_data[TRAVEL_W-1:0];
				REG_OUT_LOW:    out_low_q    <= cfg_data[OUT_W-1:0];
				REG_OUT_HIGH:   out_high_q   <= cfg_data[OUT_W-1:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q     <= '0;
			centre_y_q     <= '0;
			low_x_q        <= '0;
			high_x_q       <= '0;
			low_y_q        <= '0;
			high_y_q       <= '0;
			aligned_low_q  <= '0;
			aligned_high_q <= '0;
			centred_q      <= 1'b0;
			calibrated_q   <= 1'b0;
		end else if (accept) begin
			centre_x_q     <= centre_x_d;
			centre_y_q     <= centre_y_d;
			low_x_q        <= low_x_d;
			high_x_q       <= high_x_d;
			low_y_q        <= low_y_d;
			high_y_q       <= high_y_d;
			aligned_low_q  <= aligned_low_d;
			aligned_high_q <= aligned_high_d;
			centred_q      <= centred_d;
			calibrated_q   <= calibrated_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q  <= in_ch.x_sample;
			y_q  <= in_ch.y_sample;
			ok_q <= ok_d;
		end
	end

	// ---------------------------------------------------------------------------------
	// map unit: (v - in_lo) * (o_hi - o_lo) / (in_hi - in_lo) + o_lo, truncated toward
	// zero and wrapped to 16 bits; magnitudes go through the serial multiply and divide
	// ---------------------------------------------------------------------------------
	always_comb begin
		case (map_t'(map_idx_q))
			MAP_AX: begin
				v_sel   = OUT_W'(x_q);
				ilo_sel = low_x_q;
				ihi_sel = high_x_q;
				olo_sel = OUT_W'(aligned_low_q);
				ohi_sel = OUT_W'(aligned_high_q);
			end
			MAP_AY: begin
				v_sel   = OUT_W'(y_q);
				ilo_sel = low_y_q;
				ihi_sel = high_y_q;
				olo_sel = OUT_W'(aligned_low_q);
				ohi_sel = OUT_W'(aligned_high_q);
			end
			MAP_SX: begin
				v_sel   = ax_q;
				ilo_sel = aligned_low_q;
				ihi_sel = aligned_high_q;
				olo_sel = out_low_q;
				ohi_sel = out_high_q;
			end
			default: begin
				v_sel   = ay_q;
				ilo_sel = aligned_low_q;
				ihi_sel = aligned_high_q;
				olo_sel = out_low_q;
				ohi_sel = out_high_q;
			end
		endcase
		diff_a = DIFF_W'(v_sel) - DIFF_W'(ilo_sel);
		diff_b = DIFF_W'(ohi_sel) - DIFF_W'(olo_sel);
	end

	// one multiplier bit per cycle: add the multiplicand into the top half, shift right
	assign mul_sum = {1'b0, prod_q[PROD_W-1:OUT_W]} + (prod_q[0] ? {1'b0, mag_b_q} : '0);

	// one quotient bit per cycle: restoring step on the top dividend bit
	assign div_trial = {rem_q, prod_q[PROD_W-1]};
	assign div_take  = (div_trial >= {1'b0, span_q});
	assign div_sub   = div_trial - {1'b0, span_q};

	// only the low quotient bits survive the 16-bit wrap
	assign quo     = prod_q[OUT_W-1:0];
	assign map_res = (span_q == '0) ? olo_q : ((neg_q ? (OUT_W'(0) - quo) : quo) + olo_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				prod_q  <= {{OUT_W{1'b0}},
					(diff_a[DIFF_W-1] ? OUT_W'(-diff_a) : diff_a[OUT_W-1:0])};
				mag_b_q <= diff_b[DIFF_W-1] ? OUT_W'(-diff_b) : diff_b[OUT_W-1:0];
				neg_q   <= diff_a[DIFF_W-1] ^ diff_b[DIFF_W-1];
				span_q  <= ihi_sel - ilo_sel;
				olo_q   <= olo_sel;
				rem_q   <= '0;
			end
			ST_MUL: begin
				prod_q <= {mul_sum[OUT_W:1], mul_sum[0], prod_q[OUT_W-1:1]};
			end
			ST_DIV: begin
				rem_q  <= div_take ? div_sub[ADC_BITS-1:0] : div_trial[ADC_BITS-1:0];
				prod_q <= {prod_q[PROD_W-2:0], div_take};
			end
			ST_STORE: begin
				case (map_t'(map_idx_q))
					MAP_AX:  ax_q <= map_res;
					MAP_AY:  ay_q <= map_res;
					MAP_SX:  sx_q <= map_res;
					default: sy_q <= map_res;
				endcase
			end
			default: begin
				// unit holds between items
			end
		endcase
	end

	// ---------------------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			// uncalibrated items carry the raw samples in every field
			out_ax_q  <= calibrated_q ? ax_q : OUT_W'(x_q);
			out_ay_q  <= calibrated_q ? ay_q : OUT_W'(y_q);
			out_sx_q  <= calibrated_q ? sx_q : OUT_W'(x_q);
			out_sy_q  <= calibrated_q ? sy_q : OUT_W'(y_q);
			out_cal_q <= calibrated_q;
			out_ok_q  <= ok_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.aligned_x     = out_ax_q;
	assign out_ch.aligned_y     = out_ay_q;
	assign out_ch.scaled_x      = out_sx_q;
	assign out_ch.scaled_y      = out_sy_q;
	assign out_ch.is_calibrated = out_cal_q;
	assign out_ch.finish_ok     = out_ok_q;

endmodule
